### rtl/mtpe_pkg.sv
// shared constants and types for the multitouch to pointer event converter
// event type and code values, pointer kinds, phase encoding, millisecond scaling
// no dependencies
package mtpe_pkg;

   // input request widths
   localparam int unsigned FUNC_W  = 16;
   localparam int unsigned CODE_W  = 16;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned SEC_W   = 32;
   localparam int unsigned USEC_W  = 20;

   // result widths
   localparam int unsigned KIND_W = 2;
   localparam int unsigned POS_W  = 32;
   localparam int unsigned MS_W   = 42;

   // packed stream widths, zero padded to whole bytes
   localparam int unsigned REQ_DATA_BITS = CODE_W + VALUE_W + SEC_W + USEC_W;
   localparam int unsigned REQ_DATA_W    = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_BITS = 2 * POS_W + MS_W;
   localparam int unsigned RSP_DATA_W    = ((RSP_DATA_BITS + 7) / 8) * 8;

   // event types
   localparam logic [FUNC_W-1:0] TYPE_SYN = 16'h0000;
   localparam logic [FUNC_W-1:0] TYPE_ABS = 16'h0003;

   // event codes
   localparam logic [CODE_W-1:0] CODE_MAJOR  = 16'h0030;
   localparam logic [CODE_W-1:0] CODE_X      = 16'h0035;
   localparam logic [CODE_W-1:0] CODE_Y      = 16'h0036;
   localparam logic [CODE_W-1:0] SYN_FULL    = 16'h0000;
   localparam logic [CODE_W-1:0] SYN_CONTACT = 16'h0002;

   // pointer kinds
   localparam logic [KIND_W-1:0] KIND_UP   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE = 2'd2;

   // milliseconds per second
   localparam int unsigned MS_SCALE_W = 10;
   localparam logic [MS_SCALE_W-1:0] MS_PER_SEC = 10'd1000;

   // usec / 1000 as (usec * RECIP) >> RECIP_SHIFT, exact for every 20-bit value
   localparam int unsigned RECIP_SHIFT = 30;
   localparam int unsigned RECIP_W     = 21;
   localparam logic [RECIP_W-1:0] RECIP = 21'd1073742;
   localparam int unsigned USEC_PROD_W = USEC_W + RECIP_W;
   localparam int unsigned USEC_MS_W   = USEC_PROD_W - RECIP_SHIFT;

   // collection phase
   typedef enum logic [2:0] {
      PH_START   = 3'b001,
      PH_COLLECT = 3'b010,
      PH_IGNORE  = 3'b100
   } phase_type;

endpackage

### rtl/multitouch_to_pointer_events_core.sv
// multitouch (protocol a) event stream to single-pointer up, down and move events
// three-stage pipeline: request register, decode and scaling, result register
// depends on mtpe_pkg
//
// usage
//   req channel: one input event per request. req_tuser carries the event type,
//   req_tdata the code, signed value and timestamp. every request is taken, but
//   only a full sync produces a result; all other events only update the latches
//   or are dropped.
//   rsp channel: one pointer event per full sync, with the kind on rsp_tuser and
//   the latched x and y and the millisecond timestamp on rsp_tdata.
//   throughput: one request per cycle, sustained unless the stall below holds;
//   the latch and phase update for a request is registered as it leaves the
//   request stage, so back-to-back events see each other's effect.
//   stalls: each stage moves on whenever the stage after it is empty or moving,
//   so requests keep being taken while a result waits, until all three stages
//   hold work and rsp_tready is low.
//   reset: synchronous, active high. the phase returns to start, the latches
//   and the pressed flag clear, the pipeline empties.
module multitouch_to_pointer_events_core
   import mtpe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // from bit 0: ev_code[15:0], ev_value[31:0], time_sec[31:0], time_usec[19:0], zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // func[15:0]
   input  logic [FUNC_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // from bit 0: x_pos[31:0], y_pos[31:0], time_ms[41:0], zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // pointer_kind[1:0]
   output logic [KIND_W-1:0]      rsp_tuser
);

   // request stage
   logic                   a_vld_ff, a_vld_in;
   logic [FUNC_W-1:0]      a_func_ff;
   logic [CODE_W-1:0]      a_code_ff;
   logic [VALUE_W-1:0]     a_value_ff;
   logic [SEC_W-1:0]       a_sec_ff;
   logic [USEC_W-1:0]      a_usec_ff;

   // contact state
   phase_type              phase_ff, phase_in;
   logic [POS_W-1:0]       pos_x_ff, pos_x_in;
   logic [POS_W-1:0]       pos_y_ff, pos_y_in;
   logic [VALUE_W-1:0]     major_ff, major_in;
   logic                   pressed_ff, pressed_in;

   // scaling stage
   logic                   b_vld_ff, b_vld_in;
   logic [KIND_W-1:0]      b_kind_ff, b_kind_in;
   logic [POS_W-1:0]       b_x_ff;
   logic [POS_W-1:0]       b_y_ff;
   logic [MS_W-1:0]        b_sec_ms_ff;
   logic [USEC_MS_W-1:0]   b_usec_ms_ff;

   // result stage
   logic                   c_vld_ff, c_vld_in;
   logic [KIND_W-1:0]      c_kind_ff;
   logic [POS_W-1:0]       c_x_ff;
   logic [POS_W-1:0]       c_y_ff;
   logic [MS_W-1:0]        c_ms_ff;

   logic                   a_fire, b_adv, b_fire;
   logic                   is_abs, is_full, is_contact;
   logic [MS_W-1:0]        sec_ms;
   logic [USEC_PROD_W-1:0] usec_prod;

   assign b_adv  = !c_vld_ff || rsp_tready;
   assign b_fire = b_vld_ff && b_adv;
   assign a_fire = a_vld_ff && (!b_vld_ff || b_adv);

   assign req_tready = !a_vld_ff || a_fire;

   assign is_abs     = (a_func_ff == TYPE_ABS);
   assign is_full    = (a_func_ff == TYPE_SYN) && (a_code_ff == SYN_FULL);
   assign is_contact = (a_func_ff == TYPE_SYN) && (a_code_ff == SYN_CONTACT);

   assign sec_ms    = MS_W'(a_sec_ff) * MS_W'(MS_PER_SEC);
   assign usec_prod = USEC_PROD_W'(a_usec_ff) * USEC_PROD_W'(RECIP);

   assign a_vld_in = (req_tvalid && req_tready) || (a_vld_ff && !a_fire);
   assign b_vld_in = (a_fire && is_full) || (b_vld_ff && !b_adv);
   assign c_vld_in = b_fire || (c_vld_ff && !rsp_tready);

   always_comb begin
      phase_in   = phase_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      major_in   = major_ff;
      pressed_in = pressed_ff;
      b_kind_in  = KIND_MOVE;
      if (a_fire) begin
         if (is_abs) begin
            unique case (phase_ff)
               PH_START, PH_COLLECT: begin
                  phase_in = PH_COLLECT;
                  if (a_code_ff == CODE_MAJOR) begin
                     major_in = a_value_ff;
                  end
                  if (a_code_ff == CODE_X) begin
                     pos_x_in = a_value_ff;
                  end
                  if (a_code_ff == CODE_Y) begin
                     pos_y_in = a_value_ff;
                  end
               end
               PH_IGNORE: begin
                  phase_in = PH_IGNORE;
               end
               default: begin
                  phase_in = PH_START;
               end
            endcase
         end else if (is_contact) begin
            if (phase_ff == PH_COLLECT) begin
               phase_in = PH_IGNORE;
            end
         end else if (is_full) begin
            phase_in = PH_START;
            priority if (major_ff == '0 || phase_ff == PH_START) begin
               b_kind_in  = KIND_UP;
               pressed_in = 1'b0;
            end else if (!pressed_ff) begin
               b_kind_in  = KIND_DOWN;
               pressed_in = 1'b1;
            end else begin
               b_kind_in  = KIND_MOVE;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         phase_ff   <= PH_START;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         major_ff   <= '0;
         pressed_ff <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         c_vld_ff   <= c_vld_in;
         phase_ff   <= phase_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         major_ff   <= major_in;
         pressed_ff <= pressed_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_func_ff  <= req_tuser;
         a_code_ff  <= req_tdata[CODE_W-1:0];
         a_value_ff <= req_tdata[CODE_W+VALUE_W-1:CODE_W];
         a_sec_ff   <= req_tdata[CODE_W+VALUE_W+SEC_W-1:CODE_W+VALUE_W];
         a_usec_ff  <= req_tdata[REQ_DATA_BITS-1:CODE_W+VALUE_W+SEC_W];
      end
      if (a_fire && is_full) begin
         b_kind_ff    <= b_kind_in;
         b_x_ff       <= pos_x_ff;
         b_y_ff       <= pos_y_ff;
         b_sec_ms_ff  <= sec_ms;
         b_usec_ms_ff <= usec_prod[USEC_PROD_W-1:RECIP_SHIFT];
      end
      if (b_fire) begin
         c_kind_ff <= b_kind_ff;
         c_x_ff    <= b_x_ff;
         c_y_ff    <= b_y_ff;
         c_ms_ff   <= b_sec_ms_ff + MS_W'(b_usec_ms_ff);
      end
   end

   assign rsp_tvalid = c_vld_ff;
   assign rsp_tuser  = c_kind_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_DATA_BITS)'(0), c_ms_ff, c_y_ff, c_x_ff};

   // a full sync always leaves the phase at start
   a_full_sync_restarts: assert property (@(posedge clock) disable iff (reset)
      a_fire && is_full |=> phase_ff == PH_START)
      else $error("phase not back at start after full sync");

   // a down event leaves the pointer pressed, an up event releases it
   a_down_sets_pressed: assert property (@(posedge clock) disable iff (reset)
      a_fire && is_full && b_kind_in == KIND_DOWN |=> pressed_ff)
      else $error("pressed flag not set after down event");

   a_up_clears_pressed: assert property (@(posedge clock) disable iff (reset)
      a_fire && is_full && b_kind_in == KIND_UP |=> !pressed_ff)
      else $error("pressed flag not cleared after up event");

   // requests are refused only when every stage is full and the output stalls
   a_backpressure_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> a_vld_ff && b_vld_ff && rsp_tvalid && !rsp_tready)
      else $error("request refused while pipeline has room");

endmodule

### tb/sv/multitouch_to_pointer_events_core_tb.sv
// self-checking testbench for multitouch_to_pointer_events_core
// tracks the contact latches and phase alongside the block and checks every pointer event
// depends on mtpe_pkg and the core rtl
module multitouch_to_pointer_events_core_tb
   import mtpe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam logic [FUNC_W-1:0] TYPE_KEY = 16'h0001;
   localparam logic [CODE_W-1:0] CODE_OTHER_AXIS = 16'h0031;
   localparam logic [CODE_W-1:0] SYN_OTHER = 16'h0001;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [CODE_W-1:0]         code;
      logic signed [VALUE_W-1:0] value;
      logic [SEC_W-1:0]          sec;
      logic [USEC_W-1:0]         usec;
   } touch_ev_type;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [MS_W-1:0]         ms;
   } pointer_ev_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;

   touch_ev_type   ev_pending[$];
   pointer_ev_type pointer_due[$];
   touch_ev_type   ev_on_bus;
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;
   int unsigned ev_queued = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   // shadow of the contact tracker
   phase_type               trk_phase = PH_START;
   logic signed [POS_W-1:0] lat_x = '0;
   logic signed [POS_W-1:0] lat_y = '0;
   logic [VALUE_W-1:0]      lat_major = '0;
   logic                    is_pressed = 1'b0;

   multitouch_to_pointer_events_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // update the shadow tracker for one accepted request, queue any pointer event
   task automatic track_event(input touch_ev_type ev);
      pointer_ev_type pe;
      logic [63:0] ms_full;
      if (ev.func == TYPE_ABS) begin
         if (trk_phase != PH_IGNORE) begin
            trk_phase = PH_COLLECT;
            if (ev.code == CODE_MAJOR) lat_major = ev.value;
            else if (ev.code == CODE_X) lat_x = ev.value;
            else if (ev.code == CODE_Y) lat_y = ev.value;
         end
      end else if (ev.func == TYPE_SYN) begin
         if (ev.code == SYN_CONTACT) begin
            if (trk_phase == PH_COLLECT) trk_phase = PH_IGNORE;
         end else if (ev.code == SYN_FULL) begin
            if (lat_major == '0 || trk_phase == PH_START) begin
               pe.kind = KIND_UP;
               is_pressed = 1'b0;
            end else if (!is_pressed) begin
               pe.kind = KIND_DOWN;
               is_pressed = 1'b1;
            end else begin
               pe.kind = KIND_MOVE;
            end
            trk_phase = PH_START;
            ms_full = 64'(ev.sec) * 64'd1000 + 64'(ev.usec) / 64'd1000;
            pe.x = lat_x;
            pe.y = lat_y;
            pe.ms = ms_full[MS_W-1:0];
            pointer_due.push_back(pe);
         end
      end
   endtask

   task automatic add_ev(input logic [FUNC_W-1:0] func, input logic [CODE_W-1:0] code,
                         input logic [VALUE_W-1:0] value, input logic [SEC_W-1:0] sec,
                         input logic [USEC_W-1:0] usec);
      touch_ev_type ev;
      ev.func = func;
      ev.code = code;
      ev.value = value;
      ev.sec = sec;
      ev.usec = usec;
      ev_pending.push_back(ev);
      ev_queued++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(9);
      case (sel)
         0: pick_value = 32'h7fffffff;
         1: pick_value = 32'h80000000;
         2: pick_value = 32'hffffffff;
         3, 4, 5: pick_value = 32'($urandom_range(4095));
         default: pick_value = $urandom;
      endcase
   endfunction

   // a random frame: contacts of axis events, most closed by a per-contact sync, optional noise, usually a full sync
   task automatic push_frame();
      logic [SEC_W-1:0]   sec;
      logic [USEC_W-1:0]  usec;
      logic [VALUE_W-1:0] major;
      int unsigned        n_contacts;
      int unsigned        order;
      sec = ($urandom_range(3) == 0) ? 32'hffffffff - 32'($urandom_range(3)) : $urandom;
      usec = ($urandom_range(9) == 0) ? 20'($urandom_range(20'hfffff))
                                      : 20'($urandom_range(999999));
      n_contacts = $urandom_range(3);
      if ($urandom_range(4) == 0) n_contacts = 0;
      for (int c = 0; c < n_contacts; c++) begin
         major = ($urandom_range(5) == 0) ? '0 : pick_value();
         order = $urandom_range(2);
         if (order == 0 && $urandom_range(7) != 0) add_ev(TYPE_ABS, CODE_MAJOR, major, sec, usec);
         if ($urandom_range(7) != 0) add_ev(TYPE_ABS, CODE_X, pick_value(), sec, usec);
         if (order == 1 && $urandom_range(7) != 0) add_ev(TYPE_ABS, CODE_MAJOR, major, sec, usec);
         if ($urandom_range(7) != 0) add_ev(TYPE_ABS, CODE_Y, pick_value(), sec, usec);
         if (order == 2 && $urandom_range(7) != 0) add_ev(TYPE_ABS, CODE_MAJOR, major, sec, usec);
         if ($urandom_range(7) == 0) add_ev(TYPE_ABS, 16'($urandom), pick_value(), sec, usec);
         if ($urandom_range(9) != 0) add_ev(TYPE_SYN, SYN_CONTACT, pick_value(), sec, usec);
      end
      // noise: any type and code, plus key events
      if ($urandom_range(5) == 0) begin
         case ($urandom_range(3))
            0: add_ev(16'($urandom), 16'($urandom), $urandom, sec, usec);
            1: add_ev(TYPE_SYN, 16'($urandom), $urandom, sec, usec);
            2: add_ev(TYPE_KEY, 16'($urandom), $urandom, sec, usec);
            default: add_ev(TYPE_ABS, 16'($urandom), $urandom, sec, usec);
         endcase
      end
      if ($urandom_range(11) != 0) add_ev(TYPE_SYN, SYN_FULL, pick_value(), sec, usec);
   endtask

   task automatic load_directed();
      // full sync straight after reset: button up at the origin
      add_ev(TYPE_SYN, SYN_FULL, '0, '0, '0);
      // first touch with extreme coordinates and the largest seconds value
      add_ev(TYPE_ABS, CODE_X, 32'h7fffffff, 32'd1, 20'd0);
      add_ev(TYPE_ABS, CODE_Y, 32'h80000000, 32'd1, 20'd0);
      add_ev(TYPE_ABS, CODE_MAJOR, 32'd5, 32'd1, 20'd0);
      add_ev(TYPE_ABS, CODE_OTHER_AXIS, 32'hffffffff, 32'd1, 20'd0);
      add_ev(TYPE_SYN, SYN_FULL, '0, 32'hffffffff, 20'd999999);
      // second contact after a per-contact sync is ignored, result is a move
      add_ev(TYPE_ABS, CODE_MAJOR, 32'd7, 32'd2, 20'd1);
      add_ev(TYPE_SYN, SYN_CONTACT, '0, 32'd2, 20'd1);
      add_ev(TYPE_ABS, CODE_X, 32'd1, 32'd2, 20'd1);
      add_ev(TYPE_SYN, SYN_CONTACT, '0, 32'd2, 20'd1);
      add_ev(TYPE_SYN, SYN_FULL, '0, 32'hffffffff, 20'hfffff);
      // empty frame lifts the pointer
      add_ev(TYPE_SYN, SYN_FULL, '0, 32'd3, 20'd999);
      // unknown axis code alone still opens collection
      add_ev(TYPE_ABS, CODE_OTHER_AXIS, 32'd9, 32'd4, 20'd1000);
      add_ev(TYPE_SYN, SYN_FULL, '0, 32'd4, 20'd1000);
      // zero touch major gives button up even while collecting
      add_ev(TYPE_ABS, CODE_MAJOR, '0, 32'd5, 20'd0);
      add_ev(TYPE_SYN, SYN_FULL, '0, 32'd5, 20'd0);
      // ignored types and sync codes
      add_ev(TYPE_SYN, SYN_OTHER, 32'h12345678, 32'd6, 20'd0);
      add_ev(TYPE_KEY, CODE_X, 32'd77, 32'd6, 20'd0);
      add_ev(16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 20'hfffff);
      // per-contact sync in the start phase leaves it at start
      add_ev(TYPE_SYN, SYN_CONTACT, '0, 32'd7, 20'd0);
      add_ev(TYPE_SYN, SYN_FULL, '0, 32'd7, 20'd0);
      add_ev(TYPE_ABS, CODE_X, 32'hffffffff, 32'd8, 20'd0);
      add_ev(TYPE_SYN, SYN_FULL, '0, 32'd8, 20'd0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) track_event(ev_on_bus);
         if (!req_tvalid || req_tready) begin
            if (ev_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               ev_on_bus = ev_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_W'({ev_on_bus.usec, ev_on_bus.sec,
                                         ev_on_bus.value, ev_on_bus.code});
               req_tuser <= ev_on_bus.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      pointer_ev_type pe;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pointer_due.size() == 0) begin
               $error("pointer event with none expected: kind %0d", rsp_tuser);
               err_count++;
            end else begin
               pe = pointer_due.pop_front();
               if (rsp_tuser !== pe.kind) begin
                  $error("pointer_kind: expected %0d, got %0d", pe.kind, rsp_tuser);
                  err_count++;
               end
               if (rsp_tdata[31:0] !== pe.x) begin
                  $error("x_pos: expected %0d, got %0d", pe.x, $signed(rsp_tdata[31:0]));
                  err_count++;
               end
               if (rsp_tdata[63:32] !== pe.y) begin
                  $error("y_pos: expected %0d, got %0d", pe.y, $signed(rsp_tdata[63:32]));
                  err_count++;
               end
               if (rsp_tdata[105:64] !== pe.ms) begin
                  $error("time_ms: expected %0d, got %0d", pe.ms, rsp_tdata[105:64]);
                  err_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 75 : 0;
         recv_stall_pct = (ph == 0) ? 75 : (ph == 1) ? 30 : 0;
         if (ph == 0) load_directed();
         while (ev_queued < 520 * (ph + 1)) push_frame();
         // let this phase's requests go before changing the idle mix
         do @(posedge clock); while (ev_pending.size() > 0 || req_tvalid);
      end
      do @(posedge clock); while (pointer_due.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
